// ===== design/signed_shift_subtract_divider_unit_macros.svh =====
// Assertion macros for the signed divider top level.
`ifndef SIGNED_SHIFT_SUBTRACT_DIVIDER_UNIT_MACROS_SVH
`define SIGNED_SHIFT_SUBTRACT_DIVIDER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Implication checked on every rising edge outside reset
`define SSSD_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("sssd implication check failed");
// Condition that must never hold outside reset
`define SSSD_ASSERT_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("sssd forbidden condition seen");
`else
`define SSSD_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define SSSD_ASSERT_NEVER(lbl, ck, rn, cond)
`endif

`endif

// ===== design/sssd_pkg.sv =====
// Shared types and constants of the signed shift-subtract divider.
package sssd_pkg;

  // Default operand width
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Control bits that travel down the pipeline next to the data
  typedef struct packed {
    logic vld;   // stage holds an item
    logic neg;   // operand signs differ
    logic zdiv;  // divisor was zero
  } ctrl_t;

endpackage

// ===== design/sssd_prep.sv =====
// Input stage: captures an item, takes operand magnitudes and sign/zero flags.
module sssd_prep #(
  parameter int unsigned DATA_WIDTH = sssd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic signed [DATA_WIDTH-1:0] numerator,
  input  logic signed [DATA_WIDTH-1:0] denominator,
  output logic [DATA_WIDTH-1:0]        mag_n_r,
  output logic [DATA_WIDTH-1:0]        mag_d_r,
  output sssd_pkg::ctrl_t              ctrl_r
);
  import sssd_pkg::*;

  logic [DATA_WIDTH-1:0] n_u;
  logic [DATA_WIDTH-1:0] d_u;
  logic [DATA_WIDTH-1:0] mag_n_nxt;
  logic [DATA_WIDTH-1:0] mag_d_nxt;
  ctrl_t                 ctrl_nxt;

  // Magnitudes; the most negative value maps to 2^(W-1) unsigned
  always_comb begin
    n_u       = DATA_WIDTH'(numerator);
    d_u       = DATA_WIDTH'(denominator);
    mag_n_nxt = n_u[DATA_WIDTH-1] ? (~n_u + 1'b1) : n_u;
    mag_d_nxt = d_u[DATA_WIDTH-1] ? (~d_u + 1'b1) : d_u;
    ctrl_nxt.vld  = accept;
    ctrl_nxt.neg  = n_u[DATA_WIDTH-1] ^ d_u[DATA_WIDTH-1];
    ctrl_nxt.zdiv = (d_u == '0);
  end

  // Control bits (valid, sign, zero divisor)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    mag_n_r <= mag_n_nxt;
    mag_d_r <= mag_d_nxt;
  end

endmodule

// ===== design/sssd_step.sv =====
// One restoring shift-subtract stage: resolves one quotient bit per item.
module sssd_step #(
  parameter int unsigned DATA_WIDTH = sssd_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [DATA_WIDTH-1:0] rem_in,
  input  logic [DATA_WIDTH-1:0] aq_in,
  input  logic [DATA_WIDTH-1:0] div_in,
  input  sssd_pkg::ctrl_t       ctrl_in,
  output logic [DATA_WIDTH-1:0] rem_r,
  output logic [DATA_WIDTH-1:0] aq_r,
  output logic [DATA_WIDTH-1:0] div_r,
  output sssd_pkg::ctrl_t       ctrl_r
);
  import sssd_pkg::*;

  logic [DATA_WIDTH-1:0] trial;
  logic [DATA_WIDTH:0]   diff;
  logic [DATA_WIDTH-1:0] rem_nxt;
  logic [DATA_WIDTH-1:0] aq_nxt;

  // Shift next dividend bit into the remainder, try to subtract the divisor.
  // Remainder stays below the divisor magnitude, so W bits hold the shift.
  always_comb begin
    trial = {rem_in[DATA_WIDTH-2:0], aq_in[DATA_WIDTH-1]};
    diff  = {1'b0, trial} - {1'b0, div_in};
    if (!diff[DATA_WIDTH]) begin
      rem_nxt = diff[DATA_WIDTH-1:0];
      aq_nxt  = {aq_in[DATA_WIDTH-2:0], 1'b1};
    end else begin
      rem_nxt = trial;
      aq_nxt  = {aq_in[DATA_WIDTH-2:0], 1'b0};
    end
  end

  // Control travels with the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl_in;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    aq_r  <= aq_nxt;
    div_r <= div_in;
  end

endmodule

// ===== design/sssd_post.sv =====
// Output stage: applies the sign, saturates and flags, drives the result strobe.
module sssd_post #(
  parameter int unsigned DATA_WIDTH = sssd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [DATA_WIDTH-1:0]         mag_q,
  input  sssd_pkg::ctrl_t               ctrl_in,
  output logic                          valid_r,
  output logic signed [DATA_WIDTH-1:0]  quotient_r,
  output logic                          overflowed_r,
  output logic                          zero_divisor_r
);
  import sssd_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] quotient_nxt;
  logic                  overflowed_nxt;
  logic                  zero_divisor_nxt;

  // Zero divisor wins; a positive magnitude with the top bit set saturates
  always_comb begin
    overflowed_nxt   = 1'b0;
    zero_divisor_nxt = 1'b0;
    if (ctrl_in.zdiv) begin
      quotient_nxt     = MAX_POS;
      zero_divisor_nxt = 1'b1;
    end else if (!ctrl_in.neg && mag_q[DATA_WIDTH-1]) begin
      quotient_nxt   = MAX_POS;
      overflowed_nxt = 1'b1;
    end else if (ctrl_in.neg) begin
      quotient_nxt = ~mag_q + 1'b1;
    end else begin
      quotient_nxt = mag_q;
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctrl_in.vld;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    quotient_r     <= $signed(quotient_nxt);
    overflowed_r   <= overflowed_nxt;
    zero_divisor_r <= zero_divisor_nxt;
  end

endmodule

// ===== design/signed_shift_subtract_divider_unit.sv =====
// Top level of the pipelined signed shift-subtract divider.
//
// Usage:
//   Input: drive in_numerator / in_denominator and raise start; the item is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only during reset and the cycle after it; otherwise one item can be
//   taken every cycle.
//   Output: out_valid is high for exactly one cycle per item, with
//   out_quotient (truncated toward zero), out_overflowed (most negative
//   divided by minus one, saturated) and out_zero_divisor (divisor zero,
//   quotient then the largest positive value). Results leave in input order.
//   Path: the accepting edge loads the input stage; the item then passes one
//   restoring stage per quotient bit and one sign/saturation stage, whose
//   register holds the result.
//   Throughput: one item per cycle while busy is low, set by the fully unrolled stage chain.
//   Reset: synchronous, clears all valid bits; items in flight are dropped.
//   The receiver cannot stall; the pipeline never holds.
`include "signed_shift_subtract_divider_unit_macros.svh"

module signed_shift_subtract_divider_unit #(
  parameter int unsigned DATA_WIDTH = sssd_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_numerator,
  input  logic signed [DATA_WIDTH-1:0] in_denominator,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic                         out_overflowed,
  output logic                         out_zero_divisor
);
  import sssd_pkg::*;

  // Edges from the accepting edge to the edge that takes the result
  localparam int unsigned LAT = DATA_WIDTH + 2;
  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = {DATA_WIDTH{1'b1}};
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                  busy_r;
  logic                  accept;
  logic                  min_by_m1;  // operand pair whose quotient overflows
  logic                  sat_clean;  // saturated quotient, no overflow flag
  logic [DATA_WIDTH-1:0] rem   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] aq    [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] dvs   [0:DATA_WIDTH];
  ctrl_t                 ctrl  [0:DATA_WIDTH];

  // busy only covers reset and the first cycle after it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Input stage
  sssd_prep #(.DATA_WIDTH(DATA_WIDTH)) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .numerator   (in_numerator),
    .denominator (in_denominator),
    .mag_n_r     (aq[0]),
    .mag_d_r     (dvs[0]),
    .ctrl_r      (ctrl[0])
  );

  assign rem[0] = '0;

  // One restoring stage per quotient bit, MSB first
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    sssd_step #(.DATA_WIDTH(DATA_WIDTH)) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .rem_in  (rem[i]),
      .aq_in   (aq[i]),
      .div_in  (dvs[i]),
      .ctrl_in (ctrl[i]),
      .rem_r   (rem[i+1]),
      .aq_r    (aq[i+1]),
      .div_r   (dvs[i+1]),
      .ctrl_r  (ctrl[i+1])
    );
  end

  // Sign, saturation and result register
  sssd_post #(.DATA_WIDTH(DATA_WIDTH)) u_post (
    .clk            (clk),
    .rst_n          (rst_n),
    .mag_q          (aq[DATA_WIDTH]),
    .ctrl_in        (ctrl[DATA_WIDTH]),
    .valid_r        (out_valid),
    .quotient_r     (out_quotient),
    .overflowed_r   (out_overflowed),
    .zero_divisor_r (out_zero_divisor)
  );

  // Terms for the checks
  assign min_by_m1 = ($unsigned(in_numerator) == MOST_NEG) &&
                     ($unsigned(in_denominator) == MINUS_ONE);
  assign sat_clean = ($unsigned(out_quotient) == MAX_POS) && !out_overflowed;

  // Checks
  `SSSD_ASSERT_IMPL(a_out_has_item, clk, rst_n, out_valid, $past(accept, LAT))
  `SSSD_ASSERT_IMPL(a_ovf_cause, clk, rst_n, out_valid && out_overflowed, $past(min_by_m1, LAT))
  `SSSD_ASSERT_IMPL(a_zdiv_saturates, clk, rst_n, out_valid && out_zero_divisor, sat_clean)
  `SSSD_ASSERT_NEVER(a_busy_after_reset, clk, rst_n, busy && $past(rst_n) && $past(rst_n, 2))

endmodule
